### rtl/tcse_pkg.sv
// Package for the TCP connection state engine: phase, flag, kind and
// register codes, reset constants and the sequencer state type.
// No dependencies.
package tcse_pkg;

  localparam int unsigned NumConnsDefault = 8;

  localparam logic [15:0] AdvWindowReset  = 16'd4096;
  localparam logic [31:0] InitialSeqReset = 32'hC0DE0000;
  localparam logic [15:0] PortBaseReset   = 16'd49152;
  localparam logic [15:0] OpenPeerWin     = 16'd65535;

  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagAck = 8'h10;

  typedef enum logic [2:0] {
    PhClosed    = 3'd0,
    PhSynSent   = 3'd1,
    PhEst       = 3'd2,
    PhFw1       = 3'd3,
    PhFw2       = 3'd4,
    PhCloseWait = 3'd5,
    PhLastAck   = 3'd6,
    PhSpare     = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindSeg   = 2'd0,
    KindOpen  = 2'd1,
    KindClose = 2'd2,
    KindFree  = 2'd3
  } kind_e;

  localparam logic [1:0] RegAdvWindow  = 2'd0;
  localparam logic [1:0] RegInitialSeq = 2'd1;
  localparam logic [1:0] RegPortBase   = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StRead,
    StExec,
    StEmit
  } state_e;

endpackage

### rtl/tcse_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module tcse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/tcp_connection_state_engine.sv
// TCP connection state engine top level: slot tables, sequencer, result port.
// Depends on tcse_pkg and tcse_ram.
//
// One word is accepted when start is high and busy low. Segment words scan
// the slots one per cycle through the single read port of the slot RAM;
// open words scan the phase table for a closed slot. Close reads its slot
// from the RAM, and free only marks the slot closed.
// Up to two results follow, each on the ports for one cycle under
// result_valid_o; the receiver cannot stall them. Config writes are taken
// at any edge but belong to idle time.
module tcp_connection_state_engine #(
  parameter int unsigned NUM_CONNS = tcse_pkg::NumConnsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [31:0] peer_address_i,
  input  logic [15:0] peer_port_i,
  input  logic [15:0] own_port_i,
  input  logic [2:0]  slot_index_i,
  input  logic [7:0]  seg_flags_i,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_ack_i,
  input  logic [15:0] seg_window_i,
  input  logic [3:0]  seg_data_offset_i,
  input  logic [15:0] ip_total_length_i,
  input  logic [3:0]  ip_header_words_i,
  output logic        result_valid_o,
  output logic        status_o,
  output logic [2:0]  which_slot_o,
  output logic [7:0]  out_flags_o,
  output logic [31:0] out_seq_o,
  output logic [31:0] out_ack_o,
  output logic [15:0] out_src_port_o,
  output logic [15:0] out_dst_port_o,
  output logic [31:0] out_peer_address_o,
  output logic [15:0] out_window_o,
  output logic [2:0]  conn_phase_o,
  output logic [15:0] peer_window_o,
  output logic        last_o
);
  localparam int unsigned SW = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;
  localparam int unsigned CW = $clog2(NUM_CONNS + 1);
  // entry: own port, peer port, address, send next, recv next, peer window
  localparam int unsigned EW = 16 + 16 + 32 + 32 + 32 + 16;

  typedef struct packed {
    logic [15:0] own_port;
    logic [15:0] peer_port;
    logic [31:0] addr;
    logic [31:0] snd;
    logic [31:0] rcv;
    logic [15:0] pwin;
  } entry_t;

  tcse_pkg::state_e state_q, state_d;

  logic [15:0] adv_window_q;
  logic [31:0] initial_seq_q;
  logic [15:0] port_base_q;
  logic [15:0] next_eph_q, next_eph_d;
  tcse_pkg::phase_e phase_q [NUM_CONNS];

  // latched command word
  logic [1:0]  kind_q;
  logic [31:0] addr_q;
  logic [15:0] pport_q, oport_q;
  logic [7:0]  flags_q;
  logic [31:0] sq_q, ak_q;
  logic [15:0] win_q;
  logic        short_q;
  logic [16:0] hdr_q;
  logic [15:0] tot_q;
  logic [2:0]  idx_q;

  logic [CW-1:0] scan_q, scan_d;     // slot being read
  logic [CW-1:0] chk_q, chk_d;       // slot whose data is on rdata
  logic          chk_v_q, chk_v_d;
  logic [SW-1:0] slot_q, slot_d;
  entry_t        ent_q, ent_d;
  logic          fail_q, fail_d;
  logic [1:0]    nres_q, nres_d;
  logic [1:0]    ecnt_q, ecnt_d;
  logic [7:0]    fl0_q, fl0_d, fl1_q, fl1_d;
  logic [31:0]   sn0_q, sn0_d, sn1_q, sn1_d;

  logic          we;
  logic [SW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic          ph_we;
  tcse_pkg::phase_e ph_wval;

  tcse_ram #(.Width(EW), .Depth(NUM_CONNS)) u_tab (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  wire accept = start && (state_q == tcse_pkg::StIdle);
  assign busy = (state_q != tcse_pkg::StIdle);

  // payload length, zero if not positive
  logic [16:0] dl_w;
  logic        dl_pos;
  always_comb begin
    dl_pos = {1'b0, tot_q} > hdr_q;
    dl_w   = dl_pos ? ({1'b0, tot_q} - hdr_q) : 17'd0;
  end
  wire [31:0] sq_dl = sq_q + {15'd0, dl_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tcse_pkg::StIdle;
      adv_window_q  <= tcse_pkg::AdvWindowReset;
      initial_seq_q <= tcse_pkg::InitialSeqReset;
      port_base_q   <= tcse_pkg::PortBaseReset;
      next_eph_q    <= tcse_pkg::PortBaseReset;
      for (int i = 0; i < NUM_CONNS; i++) phase_q[i] <= tcse_pkg::PhClosed;
      scan_q  <= '0;
      chk_q   <= '0;
      chk_v_q <= 1'b0;
      ecnt_q  <= '0;
      nres_q  <= '0;
    end else begin
      state_q    <= state_d;
      next_eph_q <= next_eph_d;
      scan_q     <= scan_d;
      chk_q      <= chk_d;
      chk_v_q    <= chk_v_d;
      ecnt_q     <= ecnt_d;
      nres_q     <= nres_d;
      if (ph_we) phase_q[slot_d] <= ph_wval;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tcse_pkg::RegAdvWindow:  adv_window_q  <= cfg_wdata_i[15:0];
          tcse_pkg::RegInitialSeq: initial_seq_q <= cfg_wdata_i;
          tcse_pkg::RegPortBase:   port_base_q   <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      addr_q  <= peer_address_i;
      pport_q <= peer_port_i;
      oport_q <= own_port_i;
      flags_q <= seg_flags_i;
      sq_q    <= seg_seq_i;
      ak_q    <= seg_ack_i;
      win_q   <= seg_window_i;
      short_q <= seg_data_offset_i < 4'd5;
      hdr_q   <= {11'd0, seg_data_offset_i, 2'b00} + {11'd0, ip_header_words_i, 2'b00};
      tot_q   <= ip_total_length_i;
      idx_q   <= slot_index_i;
    end
    slot_q <= slot_d;
    ent_q  <= ent_d;
    fail_q <= fail_d;
    fl0_q  <= fl0_d;
    fl1_q  <= fl1_d;
    sn0_q  <= sn0_d;
    sn1_q  <= sn1_d;
  end

  wire idx_ok = ({{(32-3){1'b0}}, idx_q} < NUM_CONNS);

  always_comb begin
    tcse_pkg::phase_e ph;
    logic [16:0] nx;
    state_d    = state_q;
    next_eph_d = next_eph_q;
    scan_d     = scan_q;
    chk_d      = chk_q;
    chk_v_d    = 1'b0;
    slot_d     = slot_q;
    ent_d      = ent_q;
    fail_d     = fail_q;
    nres_d     = nres_q;
    ecnt_d     = ecnt_q;
    fl0_d      = fl0_q;
    fl1_d      = fl1_q;
    sn0_d      = sn0_q;
    sn1_d      = sn1_q;
    we         = 1'b0;
    waddr      = slot_q;
    wdata      = ent_q;
    ph_we      = 1'b0;
    ph_wval    = tcse_pkg::PhClosed;
    raddr      = scan_q[SW-1:0];
    ph         = phase_q[slot_q];
    nx         = '0;

    unique case (state_q)
      tcse_pkg::StIdle: begin
        if (accept) begin
          nres_d = '0;
          ecnt_d = '0;
          fail_d = 1'b0;
          scan_d = '0;
          unique case (tcse_pkg::kind_e'(kind_i))
            tcse_pkg::KindSeg, tcse_pkg::KindOpen: state_d = tcse_pkg::StScan;
            tcse_pkg::KindClose: begin
              slot_d  = slot_index_i[SW-1:0];
              scan_d  = CW'(slot_index_i[SW-1:0]);
              state_d = tcse_pkg::StRead;
            end
            tcse_pkg::KindFree: begin
              if ({{(32-3){1'b0}}, slot_index_i} < NUM_CONNS) begin
                slot_d  = slot_index_i[SW-1:0];
                ph_we   = 1'b1;
                ph_wval = tcse_pkg::PhClosed;
              end
            end
            default: ;
          endcase
        end
      end

      // one slot a cycle; RAM data for chk arrives the cycle after its read
      tcse_pkg::StScan: begin
        if (tcse_pkg::kind_e'(kind_q) == tcse_pkg::KindOpen) begin
          if (scan_q == CW'(NUM_CONNS)) begin
            fail_d  = 1'b1;
            nres_d  = 2'd1;
            state_d = tcse_pkg::StEmit;
          end else if (phase_q[scan_q[SW-1:0]] == tcse_pkg::PhClosed) begin
            slot_d  = scan_q[SW-1:0];
            state_d = tcse_pkg::StExec;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end else begin
          if (chk_v_q && phase_q[chk_q[SW-1:0]] != tcse_pkg::PhClosed &&
              rdata.own_port == oport_q && rdata.peer_port == pport_q &&
              rdata.addr == addr_q) begin
            slot_d  = chk_q[SW-1:0];
            ent_d   = rdata;
            state_d = tcse_pkg::StExec;
          end else if (scan_q == CW'(NUM_CONNS)) begin
            if (!chk_v_q) state_d = tcse_pkg::StIdle;
          end else begin
            chk_d   = scan_q;
            chk_v_d = 1'b1;
            scan_d  = scan_q + 1'b1;
          end
        end
      end

      tcse_pkg::StRead: begin
        ent_d   = rdata;
        state_d = tcse_pkg::StExec;
        if (!chk_v_q) begin
          chk_v_d = 1'b1;
          state_d = tcse_pkg::StRead;
        end
      end

      tcse_pkg::StExec: begin
        state_d = tcse_pkg::StEmit;
        priority case (tcse_pkg::kind_e'(kind_q))
          tcse_pkg::KindOpen: begin
            wdata.addr      = addr_q;
            wdata.peer_port = pport_q;
            wdata.own_port  = next_eph_q;
            wdata.snd       = initial_seq_q + 32'd1;
            wdata.rcv       = '0;
            wdata.pwin      = tcse_pkg::OpenPeerWin;
            we      = 1'b1;
            ent_d   = wdata;
            fl0_d   = tcse_pkg::FlagSyn;
            sn0_d   = initial_seq_q;
            nres_d  = 2'd1;
            ph_we   = 1'b1;
            ph_wval = tcse_pkg::PhSynSent;
            nx = {1'b0, next_eph_q} + 17'd1;
            next_eph_d = (nx[15:0] < port_base_q) ? port_base_q : nx[15:0];
          end
          tcse_pkg::KindClose: begin
            if (idx_ok && (ph == tcse_pkg::PhEst || ph == tcse_pkg::PhCloseWait)) begin
              fl0_d     = tcse_pkg::FlagFin | tcse_pkg::FlagAck;
              sn0_d     = ent_q.snd;
              wdata.snd = ent_q.snd + 32'd1;
              we        = 1'b1;
              ent_d     = wdata;
              nres_d    = 2'd1;
              ph_we     = 1'b1;
              ph_wval   = (ph == tcse_pkg::PhEst) ? tcse_pkg::PhFw1 : tcse_pkg::PhLastAck;
            end else begin
              state_d = tcse_pkg::StIdle;
            end
          end
          default: begin
            state_d = tcse_pkg::StIdle;
            if (!short_q) begin
              if ((flags_q & tcse_pkg::FlagRst) != 0) begin
                ph_we = 1'b1;
                ph_wval = tcse_pkg::PhClosed;
              end else begin
                unique case (ph)
                  tcse_pkg::PhSynSent: begin
                    if ((flags_q & (tcse_pkg::FlagSyn | tcse_pkg::FlagAck)) ==
                        (tcse_pkg::FlagSyn | tcse_pkg::FlagAck)) begin
                      wdata.rcv  = sq_q + 32'd1;
                      wdata.snd  = ak_q;
                      wdata.pwin = win_q;
                      fl0_d = tcse_pkg::FlagAck;
                      sn0_d = ak_q;
                      nres_d = 2'd1;
                      ph_we = 1'b1;
                      ph_wval = tcse_pkg::PhEst;
                    end
                  end
                  tcse_pkg::PhEst: begin
                    if ((flags_q & tcse_pkg::FlagAck) != 0) wdata.pwin = win_q;
                    if (dl_pos) wdata.rcv = sq_dl;
                    if ((flags_q & tcse_pkg::FlagFin) != 0) begin
                      wdata.rcv = sq_dl + 32'd1;
                      fl0_d = tcse_pkg::FlagAck;
                      fl1_d = tcse_pkg::FlagFin | tcse_pkg::FlagAck;
                      sn0_d = ent_q.snd;
                      sn1_d = ent_q.snd;
                      wdata.snd = ent_q.snd + 32'd1;
                      nres_d = 2'd2;
                      ph_we = 1'b1;
                      ph_wval = tcse_pkg::PhLastAck;
                    end else if (dl_pos) begin
                      fl0_d = tcse_pkg::FlagAck;
                      sn0_d = ent_q.snd;
                      nres_d = 2'd1;
                    end
                  end
                  tcse_pkg::PhFw1, tcse_pkg::PhFw2: begin
                    sn0_d = ent_q.snd;
                    sn1_d = ent_q.snd;
                    fl0_d = tcse_pkg::FlagAck;
                    fl1_d = tcse_pkg::FlagAck;
                    if (dl_pos) begin
                      wdata.rcv = sq_dl;
                      nres_d = 2'd1;
                    end
                    if ((flags_q & tcse_pkg::FlagFin) != 0) begin
                      wdata.rcv = sq_dl + 32'd1;
                      nres_d = dl_pos ? 2'd2 : 2'd1;
                      ph_we = 1'b1;
                      ph_wval = tcse_pkg::PhClosed;
                    end else if (ph == tcse_pkg::PhFw1 &&
                                 (flags_q & tcse_pkg::FlagAck) != 0) begin
                      ph_we = 1'b1;
                      ph_wval = tcse_pkg::PhFw2;
                    end
                  end
                  tcse_pkg::PhLastAck: begin
                    if ((flags_q & tcse_pkg::FlagAck) != 0) begin
                      ph_we = 1'b1;
                      ph_wval = tcse_pkg::PhClosed;
                    end
                  end
                  default: ;
                endcase
                we    = 1'b1;
                ent_d = wdata;
                // in fin_wait the first result's sequence is the stored send next
                if (ph == tcse_pkg::PhFw1 || ph == tcse_pkg::PhFw2) begin
                  sn0_d = ent_q.snd;
                end
              end
            end
            if (nres_d != 2'd0) state_d = tcse_pkg::StEmit;
          end
        endcase
      end

      tcse_pkg::StEmit: begin
        ecnt_d = ecnt_q + 2'd1;
        if (ecnt_q + 2'd1 == nres_q) state_d = tcse_pkg::StIdle;
      end

      default: state_d = tcse_pkg::StIdle;
    endcase
  end

  // ack per result: fin_wait data ACK reports seq+dl, its FIN ACK seq+dl+1;
  // every other ACK reports the stored receive next; results without ACK report zero
  logic [31:0] ack0_q, ack1_q;
  always_ff @(posedge clk_i) begin
    if (state_q == tcse_pkg::StExec) begin
      ack0_q <= ent_d.rcv;
      ack1_q <= ent_d.rcv;
      if (tcse_pkg::kind_e'(kind_q) == tcse_pkg::KindSeg &&
          (phase_q[slot_q] == tcse_pkg::PhFw1 || phase_q[slot_q] == tcse_pkg::PhFw2) &&
          dl_pos && (flags_q & tcse_pkg::FlagFin) == 0) begin
        ack0_q <= sq_dl;
      end else if (tcse_pkg::kind_e'(kind_q) == tcse_pkg::KindSeg &&
          (phase_q[slot_q] == tcse_pkg::PhFw1 || phase_q[slot_q] == tcse_pkg::PhFw2) &&
          dl_pos) begin
        ack0_q <= sq_dl;
      end
    end
  end

  wire [7:0] cur_fl = ecnt_q[0] ? fl1_q : fl0_q;
  wire emitting = (state_q == tcse_pkg::StEmit);

  assign result_valid_o     = emitting;
  assign status_o           = fail_q;
  assign which_slot_o       = fail_q ? 3'd0 : 3'(slot_q);
  assign out_flags_o        = fail_q ? 8'd0 : cur_fl;
  assign out_seq_o          = fail_q ? 32'd0 : (ecnt_q[0] ? sn1_q : sn0_q);
  assign out_ack_o          = (fail_q || (cur_fl & tcse_pkg::FlagAck) == 0) ? 32'd0 :
                              (ecnt_q[0] ? ack1_q : ack0_q);
  assign out_src_port_o     = fail_q ? 16'd0 : ent_q.own_port;
  assign out_dst_port_o     = fail_q ? 16'd0 : ent_q.peer_port;
  assign out_peer_address_o = fail_q ? 32'd0 : ent_q.addr;
  assign out_window_o       = fail_q ? 16'd0 : adv_window_q;
  assign conn_phase_o       = fail_q ? 3'd0 : phase_q[slot_q];
  assign peer_window_o      = fail_q ? 16'd0 : ent_q.pwin;
  assign last_o             = emitting && (ecnt_q + 2'd1 == nres_q);

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (nres_q == 2'd1 || nres_q == 2'd2)) else $error("bad count");
  a_fail_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> last_o) else $error("fail not last");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o) else $error("extra result");
`endif
endmodule
